@@ src/polynomial_boundary_point_filter_defines.svh @@
// ----------------------------------------------------------------------------
// Polynomial boundary point filter: assertion macros
// Shared concurrent check forms, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef POLYNOMIAL_BOUNDARY_POINT_FILTER_DEFINES_SVH
`define POLYNOMIAL_BOUNDARY_POINT_FILTER_DEFINES_SVH

// same-cycle implication
`define PBPF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pbpf: same-cycle check failed");

// next-cycle implication
`define PBPF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pbpf: next-cycle check failed");

`endif

@@ src/pbpf_pkg.sv @@
// ----------------------------------------------------------------------------
// Polynomial boundary point filter: package
// Widths, register indexes, mode codes, reset values and shared types.
// ----------------------------------------------------------------------------
package pbpf_pkg;

  localparam int X_W        = 24;
  localparam int COEF_W     = 32;
  localparam int CHUNK_W    = 32;
  localparam int MUL_A_W    = CHUNK_W + 1;
  localparam int PROD_W     = MUL_A_W + X_W;
  localparam int OPR_W      = 3 * CHUNK_W;
  localparam int ACC_W      = 112;
  localparam int SLOT_W     = 4;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int IN_DATA_W  = 48;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 8;
  localparam int OUT_USER_W = 2;

  localparam logic [CFG_ADDR_W-1:0] REG_POLY_DEGREE   = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_CONST    = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_LIN      = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_SQ       = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_COEF_CUBE     = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_BOUNDARY_MODE = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_X_LOWER       = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_X_UPPER       = 3'd7;

  localparam logic [1:0] MODE_KEEP_ALL = 2'd0;
  localparam logic [1:0] MODE_ABOVE    = 2'd1;
  localparam logic [1:0] MODE_BELOW    = 2'd2;

  localparam logic [1:0] DEG_SQ   = 2'd2;
  localparam logic [1:0] DEG_CUBE = 2'd3;

  localparam logic [1:0] LAST_STEP = 2'd2;

  localparam logic        [1:0]        RST_POLY_DEGREE   = 2'd2;
  localparam logic signed [COEF_W-1:0] RST_COEF_CONST    = 32'sd100663296;
  localparam logic signed [COEF_W-1:0] RST_COEF_LIN      = -32'sd24949;
  localparam logic signed [COEF_W-1:0] RST_COEF_SQ       = 32'sd24949;
  localparam logic signed [COEF_W-1:0] RST_COEF_CUBE     = 32'sd0;
  localparam logic        [1:0]        RST_BOUNDARY_MODE = 2'd1;
  localparam logic signed [X_W-1:0]    RST_X_LOWER       = -24'sd23808;
  localparam logic signed [X_W-1:0]    RST_X_UPPER       = 24'sd24064;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_DECIDE
  } state_t;

  typedef struct packed {
    logic       load;
    logic       mul;
    logic       add;
    logic [1:0] chunk;
    logic       last_chunk;
    logic       step_end;
    logic [1:0] step;
    logic       emit;
  } dp_cmd_t;

endpackage

@@ src/pbpf_ctrl.sv @@
// ----------------------------------------------------------------------------
// Polynomial boundary point filter: controller
// Sequences the Horner steps and the chunked multiply, owns the handshakes.
// ----------------------------------------------------------------------------
`include "polynomial_boundary_point_filter_defines.svh"

module pbpf_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  logic               eval_in,
  output pbpf_pkg::dp_cmd_t  cmd
);

  pbpf_pkg::state_t state_r, state_nxt;
  logic [1:0] chunk_r, chunk_nxt;
  logic [1:0] step_r, step_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;
  logic       last_chunk;
  logic       emit;

  assign in_tready  = (state_r == pbpf_pkg::ST_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign last_chunk = (chunk_r == step_r);
  assign emit       = (state_r == pbpf_pkg::ST_DECIDE) && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pbpf_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = eval_in ? pbpf_pkg::ST_MUL : pbpf_pkg::ST_DECIDE;
        end
      end
      pbpf_pkg::ST_MUL: begin
        state_nxt = pbpf_pkg::ST_ADD;
      end
      pbpf_pkg::ST_ADD: begin
        if (last_chunk && (step_r == pbpf_pkg::LAST_STEP)) begin
          state_nxt = pbpf_pkg::ST_DECIDE;
        end else begin
          state_nxt = pbpf_pkg::ST_MUL;
        end
      end
      pbpf_pkg::ST_DECIDE: begin
        if (emit) begin
          state_nxt = pbpf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = pbpf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.load       = accept;
    cmd.mul        = (state_r == pbpf_pkg::ST_MUL);
    cmd.add        = (state_r == pbpf_pkg::ST_ADD);
    cmd.chunk      = chunk_r;
    cmd.last_chunk = last_chunk;
    cmd.step_end   = (state_r == pbpf_pkg::ST_ADD) && last_chunk;
    cmd.step       = step_r;
    cmd.emit       = emit;
  end

  always_comb begin
    chunk_nxt = chunk_r;
    step_nxt  = step_r;
    if (accept) begin
      chunk_nxt = 2'd0;
      step_nxt  = 2'd0;
    end else if (state_r == pbpf_pkg::ST_ADD) begin
      if (last_chunk) begin
        chunk_nxt = 2'd0;
        step_nxt  = step_r + 2'd1;
      end else begin
        chunk_nxt = chunk_r + 2'd1;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pbpf_pkg::ST_IDLE;
      chunk_r     <= 2'd0;
      step_r      <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chunk_r     <= chunk_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `PBPF_ASSERT_IMP(a_chunk_in_step, state_r == pbpf_pkg::ST_MUL || state_r == pbpf_pkg::ST_ADD, chunk_r <= step_r && step_r <= pbpf_pkg::LAST_STEP)
  `PBPF_ASSERT_NEXT(a_one_in_flight, in_tvalid && in_tready, !in_tready)
  `PBPF_ASSERT_NEXT(a_emit_shows, emit, out_valid_r)

endmodule

@@ src/pbpf_datapath.sv @@
// ----------------------------------------------------------------------------
// Polynomial boundary point filter: datapath
// Config registers, clamp, chunked Horner evaluation, boundary test, counters.
// ----------------------------------------------------------------------------
`include "polynomial_boundary_point_filter_defines.svh"

module pbpf_datapath #(
  parameter int MAX_CIRCLES = 16,
  parameter int MAX_LAMPS   = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [pbpf_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [pbpf_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic [pbpf_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic [pbpf_pkg::IN_USER_W-1:0]      in_tuser,
  input  pbpf_pkg::dp_cmd_t                   cmd,
  output logic                                eval_in,
  output logic [pbpf_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic [pbpf_pkg::OUT_USER_W-1:0]     out_tuser
);

  localparam int XW   = pbpf_pkg::X_W;
  localparam int CW   = pbpf_pkg::COEF_W;
  localparam int AW   = pbpf_pkg::ACC_W;
  localparam int OW   = pbpf_pkg::OPR_W;
  localparam int PW   = pbpf_pkg::PROD_W;
  localparam int KW   = pbpf_pkg::CHUNK_W;
  localparam int SW   = pbpf_pkg::SLOT_W;
  localparam int CIRC_W = $clog2(MAX_CIRCLES + 1);
  localparam int LAMP_W = $clog2(MAX_LAMPS + 1);

  // configuration
  logic        [1:0]    poly_degree_r;
  logic signed [CW-1:0] coef_const_r, coef_lin_r, coef_sq_r, coef_cube_r;
  logic        [1:0]    boundary_mode_r;
  logic signed [XW-1:0] x_lower_r, x_upper_r;

  // item state
  logic signed [XW-1:0] xc_r, xc_nxt;
  logic signed [XW-1:0] y_r;
  logic                 valid_r, kind_r, eval_r;
  logic signed [OW-1:0] opr_r, opr_nxt;
  logic signed [AW-1:0] acc_r, acc_nxt;
  logic signed [PW-1:0] prod_r;
  logic [CIRC_W-1:0]    circ_cnt_r, circ_cnt_nxt;
  logic [LAMP_W-1:0]    lamp_cnt_r, lamp_cnt_nxt;
  logic                 kept_r, kept_nxt, lost_r, lost_nxt;
  logic [SW-1:0]        slot_r, slot_nxt;

  logic                 in_frame, in_kind, in_valid;
  logic signed [XW-1:0] x_in, y_in;
  logic signed [CW-1:0] c3_eff, c2_eff;
  logic [KW-1:0]        chunk_bits;
  logic signed [PW-1:0] prod_c;
  logic signed [AW-1:0] prod_ext, prod_shift, acc_sum;
  logic signed [AW-1:0] addend_lin, addend_const;
  logic                 s_neg, s_zero, pass;
  logic                 circ_full, lamp_full;
  logic [CIRC_W+SW-1:0] circ_wide;
  logic [LAMP_W+SW-1:0] lamp_wide;

  assign in_frame = in_tuser[0];
  assign in_kind  = in_tuser[1];
  assign in_valid = in_tuser[2];
  assign x_in     = in_tdata[XW-1:0];
  assign y_in     = in_tdata[2*XW-1:XW];

  assign eval_in = in_valid && ((boundary_mode_r == pbpf_pkg::MODE_ABOVE) ||
                                (boundary_mode_r == pbpf_pkg::MODE_BELOW));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_degree_r   <= pbpf_pkg::RST_POLY_DEGREE;
      coef_const_r    <= pbpf_pkg::RST_COEF_CONST;
      coef_lin_r      <= pbpf_pkg::RST_COEF_LIN;
      coef_sq_r       <= pbpf_pkg::RST_COEF_SQ;
      coef_cube_r     <= pbpf_pkg::RST_COEF_CUBE;
      boundary_mode_r <= pbpf_pkg::RST_BOUNDARY_MODE;
      x_lower_r       <= pbpf_pkg::RST_X_LOWER;
      x_upper_r       <= pbpf_pkg::RST_X_UPPER;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        pbpf_pkg::REG_POLY_DEGREE:   poly_degree_r   <= cfg_wdata[1:0];
        pbpf_pkg::REG_COEF_CONST:    coef_const_r    <= cfg_wdata[CW-1:0];
        pbpf_pkg::REG_COEF_LIN:      coef_lin_r      <= cfg_wdata[CW-1:0];
        pbpf_pkg::REG_COEF_SQ:       coef_sq_r       <= cfg_wdata[CW-1:0];
        pbpf_pkg::REG_COEF_CUBE:     coef_cube_r     <= cfg_wdata[CW-1:0];
        pbpf_pkg::REG_BOUNDARY_MODE: boundary_mode_r <= cfg_wdata[1:0];
        pbpf_pkg::REG_X_LOWER:       x_lower_r       <= cfg_wdata[XW-1:0];
        pbpf_pkg::REG_X_UPPER:       x_upper_r       <= cfg_wdata[XW-1:0];
        default: ;
      endcase
    end
  end

  // clamp: when the bounds cross, inputs below the lower bound take it and all others take the upper bound
  always_comb begin
    priority if (x_in < x_lower_r) begin
      xc_nxt = x_lower_r;
    end else if (x_in > x_upper_r) begin
      xc_nxt = x_upper_r;
    end else begin
      xc_nxt = x_in;
    end
  end

  assign c3_eff = (poly_degree_r == pbpf_pkg::DEG_CUBE) ? coef_cube_r : '0;
  assign c2_eff = ((poly_degree_r == pbpf_pkg::DEG_SQ) ||
                   (poly_degree_r == pbpf_pkg::DEG_CUBE)) ? coef_sq_r : '0;

  assign addend_lin   = AW'(coef_lin_r) <<< 16;
  assign addend_const = (AW'(coef_const_r) <<< 24) + (AW'(y_r) <<< 40);

  // chunked multiply: top chunk of a step signed, lower ones unsigned
  always_comb begin
    unique case (cmd.chunk)
      2'd0:    chunk_bits = opr_r[KW-1:0];
      2'd1:    chunk_bits = opr_r[2*KW-1:KW];
      default: chunk_bits = opr_r[3*KW-1:2*KW];
    endcase
  end

  assign prod_c   = $signed({cmd.last_chunk & chunk_bits[KW-1], chunk_bits}) * xc_r;
  assign prod_ext = AW'(prod_r);

  always_comb begin
    unique case (cmd.chunk)
      2'd0:    prod_shift = prod_ext;
      2'd1:    prod_shift = prod_ext <<< KW;
      default: prod_shift = prod_ext <<< (2 * KW);
    endcase
  end

  assign acc_sum = acc_r + prod_shift;

  always_comb begin
    opr_nxt = opr_r;
    acc_nxt = acc_r;
    if (cmd.load) begin
      opr_nxt = OW'(c3_eff);
      acc_nxt = AW'(c2_eff) <<< 8;
    end else if (cmd.add) begin
      if (cmd.step_end) begin
        opr_nxt = acc_sum[OW-1:0];
        acc_nxt = (cmd.step == 2'd0) ? addend_lin : addend_const;
        if (cmd.step == pbpf_pkg::LAST_STEP) begin
          acc_nxt = acc_sum;
        end
      end else begin
        acc_nxt = acc_sum;
      end
    end
  end

  // boundary test and slot assignment
  assign s_neg  = acc_r[AW-1];
  assign s_zero = (acc_r == '0);

  always_comb begin
    if (!eval_r) begin
      pass = valid_r;
    end else if (boundary_mode_r == pbpf_pkg::MODE_ABOVE) begin
      pass = s_neg || s_zero;
    end else begin
      pass = !s_neg;
    end
  end

  assign circ_full = (circ_cnt_r >= CIRC_W'(MAX_CIRCLES));
  assign lamp_full = (lamp_cnt_r >= LAMP_W'(MAX_LAMPS));
  assign circ_wide = {{SW{1'b0}}, circ_cnt_r};
  assign lamp_wide = {{SW{1'b0}}, lamp_cnt_r};

  always_comb begin
    kept_nxt     = 1'b0;
    lost_nxt     = 1'b0;
    slot_nxt     = '0;
    circ_cnt_nxt = circ_cnt_r;
    lamp_cnt_nxt = lamp_cnt_r;
    if (cmd.load && in_frame) begin
      circ_cnt_nxt = '0;
      lamp_cnt_nxt = '0;
    end else if (cmd.emit && pass) begin
      if (kind_r) begin
        if (lamp_full) begin
          lost_nxt = 1'b1;
        end else begin
          kept_nxt     = 1'b1;
          slot_nxt     = lamp_wide[SW-1:0];
          lamp_cnt_nxt = lamp_cnt_r + LAMP_W'(1);
        end
      end else begin
        if (circ_full) begin
          lost_nxt = 1'b1;
        end else begin
          kept_nxt     = 1'b1;
          slot_nxt     = circ_wide[SW-1:0];
          circ_cnt_nxt = circ_cnt_r + CIRC_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      circ_cnt_r <= '0;
      lamp_cnt_r <= '0;
    end else begin
      circ_cnt_r <= circ_cnt_nxt;
      lamp_cnt_r <= lamp_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      xc_r    <= xc_nxt;
      y_r     <= y_in;
      valid_r <= in_valid;
      kind_r  <= in_kind;
      eval_r  <= eval_in;
    end
    if (cmd.mul) begin
      prod_r <= prod_c;
    end
    if (cmd.emit) begin
      kept_r <= kept_nxt;
      lost_r <= lost_nxt;
      slot_r <= slot_nxt;
    end
    opr_r <= opr_nxt;
    acc_r <= acc_nxt;
  end

  assign out_tdata = {{(pbpf_pkg::OUT_DATA_W - SW){1'b0}}, slot_r};
  assign out_tuser = {lost_r, kept_r};

  `PBPF_ASSERT_IMP(a_count_cap, 1'b1, circ_cnt_r <= CIRC_W'(MAX_CIRCLES) && lamp_cnt_r <= LAMP_W'(MAX_LAMPS))
  `PBPF_ASSERT_NEXT(a_kept_or_lost, cmd.emit, !(kept_r && lost_r) && (kept_r || slot_r == '0))

endmodule

@@ src/polynomial_boundary_point_filter.sv @@
// ----------------------------------------------------------------------------
// Polynomial boundary point filter
// Keeps detected points on one side of a cubic boundary and hands out slots.
// ----------------------------------------------------------------------------
// Input stream: one detected point per item; x and y in tdata, frame start,
// kind and valid flags in tuser. Output stream: one result per item; the
// slot in tdata, kept and lost-full flags in tuser. Configuration: a plain
// write port; write registers only while no item is in flight.
// Items that need the boundary test are evaluated on the single shared 33x24
// multiplier: three Horner steps of one, two and three 32-bit chunks, each
// chunk a multiply state and then an accumulate state, followed by the
// decision state. Invalid items and keep-all modes go straight from
// acceptance to the decision state. One item is in flight at a time: a new
// item is taken only once the decision for the last one has been made.
// The result sits in an output register; the next item is taken while it
// waits. A stalled receiver holds the result and stops the decision stage.
// Reset restores the default coefficients and clears both slot counters.
// ----------------------------------------------------------------------------
module polynomial_boundary_point_filter #(
  parameter int MAX_CIRCLES = 16,
  parameter int MAX_LAMPS   = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr_en,
  input  logic [pbpf_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [pbpf_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [pbpf_pkg::IN_DATA_W-1:0]     in_tdata,   // x_pos, y_pos
  input  logic [pbpf_pkg::IN_USER_W-1:0]     in_tuser,   // frame_start, item_kind, item_valid
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [pbpf_pkg::OUT_DATA_W-1:0]    out_tdata,  // slot, zero fill
  output logic [pbpf_pkg::OUT_USER_W-1:0]    out_tuser   // kept, lost_full
);

  pbpf_pkg::dp_cmd_t cmd;
  logic              eval_in;

  pbpf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .eval_in    (eval_in),
    .cmd        (cmd)
  );

  pbpf_datapath #(
    .MAX_CIRCLES (MAX_CIRCLES),
    .MAX_LAMPS   (MAX_LAMPS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd       (cmd),
    .eval_in   (eval_in),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule
